// ===== rtl/ilid_pkg.sv =====
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and codes for the indexed list unit
// Command and status codes, word layouts and cell operation kinds.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int DEF_LIST_DEPTH  = 16;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_PUSH   = 3'd1,
        CMD_POP    = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_kind_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0]    value_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } out_word_t;

endpackage

// ===== rtl/indexed_list_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit: ordered list with insert and delete
// Keeps up to LIST_DEPTH values in a row of cells and runs get, push, pop,
// insert-at and delete-at commands, one result word per command.
//
// Input channel s_*: one command word per handshake (command, position,
// value_in). Result channel m_*: one word per command (value_out, status,
// count). Insert and delete move every later entry in the same cycle, each
// cell taking its neighbor's value. m_valid rises in the cycle after the
// input handshake; a new command is taken every cycle while the result
// register is empty or being drained. When the receiver stalls, the
// result word holds and s_ready drops until it is taken. Errors (bad
// position, empty, full, unknown command) change nothing and report the
// old count. Reset empties the list and the result register; entry
// contents are not cleared and never show.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit #(
    parameter int LIST_DEPTH  = ilid_pkg::DEF_LIST_DEPTH,
    parameter int VALUE_WIDTH = ilid_pkg::DEF_VALUE_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ilid_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output ilid_pkg::out_word_t m_word
);
    import ilid_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic                   out_valid_reg;
    out_word_t              out_word_reg;

    logic                   accept;
    logic [SEL_W-1:0]       pos_ext;
    logic [SEL_W-1:0]       fill_ext;
    logic [SEL_W-1:0]       sel_pos;
    logic [IDX_W-1:0]       rd_idx;
    logic                   rd_en;
    cell_kind_t             dec_kind;
    cell_kind_t             kind;
    status_t                status;
    logic [VALUE_WIDTH-1:0] load_value;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [VALUE_WIDTH-1:0] cell_q [LIST_DEPTH];

    assign s_ready  = aresetn && (!out_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign pos_ext  = SEL_W'(s_word.position);
    assign fill_ext = SEL_W'(fill_reg);
    assign load_value = s_word.value_in[VALUE_WIDTH-1:0];

    always_comb begin
        dec_kind  = CELL_HOLD;
        status    = ST_OK;
        sel_pos   = pos_ext;
        rd_idx    = '0;
        rd_en     = 1'b0;
        fill_next = fill_reg;
        case (s_word.command)
            CMD_GET: begin
                if (pos_ext < fill_ext) begin
                    rd_idx = pos_ext[IDX_W-1:0];
                    rd_en  = 1'b1;
                end else begin
                    status = ST_RANGE;
                end
            end
            CMD_PUSH: begin
                if (fill_reg == FULL_COUNT) begin
                    status = ST_FULL;
                end else begin
                    dec_kind  = CELL_WRITE;
                    sel_pos   = fill_ext;
                    fill_next = fill_reg + 1'b1;
                end
            end
            CMD_POP: begin
                if (fill_reg == '0) begin
                    status = ST_RANGE;
                end else begin
                    fill_next = fill_reg - 1'b1;
                    rd_idx    = fill_next[IDX_W-1:0];
                    rd_en     = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_ext > fill_ext) begin
                    status = ST_RANGE;
                end else if (fill_reg == FULL_COUNT) begin
                    status = ST_FULL;
                end else begin
                    dec_kind  = CELL_INSERT;
                    fill_next = fill_reg + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (pos_ext >= fill_ext) begin
                    status = ST_RANGE;
                end else begin
                    dec_kind  = CELL_DELETE;
                    rd_idx    = pos_ext[IDX_W-1:0];
                    rd_en     = 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            default: status = ST_RANGE;
        endcase
    end

    assign kind     = accept ? dec_kind : CELL_HOLD;
    assign rd_value = rd_en ? cell_q[rd_idx] : '0;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] below;
        logic [VALUE_WIDTH-1:0] above;
        if (i == 0) begin : g_first
            assign below = '0;
        end else begin : g_below
            assign below = cell_q[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign above = cell_q[i];
        end else begin : g_above
            assign above = cell_q[i+1];
        end
        ilid_cell #(
            .CELL_INDEX  (i),
            .VALUE_WIDTH (VALUE_WIDTH),
            .SEL_W       (SEL_W)
        ) u_cell (
            .aclk        (aclk),
            .kind        (kind),
            .sel_pos     (sel_pos),
            .load_value  (load_value),
            .below_value (below),
            .above_value (above),
            .value       (cell_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_word_reg.value_out <= VAL_W'(rd_value);
            out_word_reg.status    <= status;
            out_word_reg.count     <= COUNT_W'(fill_next);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

// ===== rtl/ilid_cell.sv =====
// ----------------------------------------------------------------------------
// ilid_cell: one list entry
// Holds one value; loads it, takes it from the neighbor below or above,
// or holds, as the broadcast operation and its own place decide.
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int VALUE_WIDTH = ilid_pkg::DEF_VALUE_WIDTH,
    parameter int SEL_W       = ilid_pkg::POS_W
) (
    input  logic                   aclk,
    input  ilid_pkg::cell_kind_t   kind,
    input  logic [SEL_W-1:0]       sel_pos,
    input  logic [VALUE_WIDTH-1:0] load_value,
    input  logic [VALUE_WIDTH-1:0] below_value,
    input  logic [VALUE_WIDTH-1:0] above_value,
    output logic [VALUE_WIDTH-1:0] value
);
    import ilid_pkg::*;

    localparam logic [SEL_W-1:0] MY_POS = SEL_W'(CELL_INDEX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (kind)
            CELL_WRITE: begin
                if (MY_POS == sel_pos) value_next = load_value;
            end
            CELL_INSERT: begin
                if (MY_POS == sel_pos) value_next = load_value;
                else if (MY_POS > sel_pos) value_next = below_value;
            end
            CELL_DELETE: begin
                if (MY_POS >= sel_pos) value_next = above_value;
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
